// ===== design/joystick_jog_position_control_core_defines.svh =====
// assertion macros for the joystick jog position control core
`ifndef JOYSTICK_JOG_POSITION_CONTROL_CORE_DEFINES_SVH
`define JOYSTICK_JOG_POSITION_CONTROL_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define JJPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define JJPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/jjpc_pkg.sv =====
// shared types and constants for the joystick jog position control core
package jjpc_pkg;

  localparam int unsigned AdcW   = 10;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned NJoint = 4;

  typedef logic [AdcW-1:0] adc_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [CfgW-1:0] cfg_reg_t;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] RegDebounceLimit = 3'd0;
  localparam logic [2:0] RegStepInterval  = 3'd1;
  localparam logic [2:0] RegHighThreshold = 3'd2;
  localparam logic [2:0] RegLowThreshold  = 3'd3;
  localparam logic [2:0] RegPositionMax   = 3'd4;
  localparam logic [2:0] RegPositionMin   = 3'd5;

  // register reset values
  localparam cfg_reg_t DebounceLimitRst = 8'd100;
  localparam cfg_reg_t StepIntervalRst  = 8'd20;
  localparam cfg_reg_t HighThresholdRst = 8'd200;
  localparam cfg_reg_t LowThresholdRst  = 8'd50;
  localparam cfg_reg_t PositionMaxRst   = 8'd240;
  localparam cfg_reg_t PositionMinRst   = 8'd10;

  localparam pos_t JointRst = 8'd125;

  // joint slots
  localparam int unsigned JointRotation = 0;
  localparam int unsigned JointArm      = 1;
  localparam int unsigned JointHand     = 2;
  localparam int unsigned JointForearm  = 3;

  typedef struct packed {
    cfg_reg_t debounce_limit;
    cfg_reg_t step_interval;
    cfg_reg_t high_threshold;
    cfg_reg_t low_threshold;
    cfg_reg_t position_max;
    cfg_reg_t position_min;
  } cfg_t;

endpackage

// ===== design/jjpc_if.sv =====
// item channels of the joystick jog position control core
interface jjpc_in_if;
  import jjpc_pkg::*;
  logic valid;
  logic ready;
  adc_t adc_sample;
  logic button_level;

  modport source (output valid, output adc_sample, output button_level, input ready);
  modport sink (input valid, input adc_sample, input button_level, output ready);
endinterface

interface jjpc_out_if;
  import jjpc_pkg::*;
  logic valid;
  logic ready;
  pos_t rotation_pos;
  pos_t arm_pos;
  pos_t hand_pos;
  pos_t forearm_pos;
  logic lower_mode;
  logic next_channel;
  logic step_taken;

  modport source (
    output valid, output rotation_pos, output arm_pos, output hand_pos,
    output forearm_pos, output lower_mode, output next_channel, output step_taken,
    input ready
  );
  modport sink (
    input valid, input rotation_pos, input arm_pos, input hand_pos,
    input forearm_pos, input lower_mode, input next_channel, input step_taken,
    output ready
  );
endinterface

// ===== design/joystick_jog_position_control_core.sv =====
// top level of the joystick jog position control core
// Each input item is one joystick conversion (10 bits, top 8 kept as the axis value of the
// current channel, which alternates x then y) plus the raw mode button level. A counting
// debouncer turns the button into a press pulse that toggles lower/upper mode. Every
// step_interval+1 items the x and y axes each jog one joint of the active mode by one
// (lower: rotation and arm, upper: hand and forearm) when above high_threshold or below
// low_threshold, clamped by position_max and position_min. Exactly one result item per
// input item. An item passes the input register and then the result register; the
// combinational update between them lets a new item be taken every clock while the output
// is not stalled, and the result register lets the next item enter while a result waits.
// Registers sit on an APB-style port at byte address 4*index and should be written only
// while the block is idle.
module joystick_jog_position_control_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jjpc_pkg::AddrW-1:0]   paddr,
  input  logic [jjpc_pkg::DataW-1:0]   pwdata,
  output logic [jjpc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  jjpc_in_if.sink                      in_i,
  jjpc_out_if.source                   out_o
);
  import jjpc_pkg::*;

`include "joystick_jog_position_control_core_defines.svh"

  // configuration registers
  cfg_t        cfg_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  cfg_reg_t    cfg_rd;

  // input register
  logic        s1_valid_q;
  adc_t        s1_sample_q;
  logic        s1_level_q;
  logic        s1_adv;

  // block state
  pos_t                   x_q, y_q, x_d, y_d;
  logic                   chan_q, chan_d;
  logic                   mode_q, mode_d;
  logic [7:0]             item_q, item_d, item_inc;
  logic [7:0]             dbc_q, dbc_d, dbc_inc;
  logic                   stable_q, stable_d;
  logic                   pulse;
  logic                   step;
  logic [NJoint-1:0][PosW-1:0] joint_q, joint_d;
  pos_t                   sample8;

  // result register
  logic        out_valid_q;
  logic        step_out_q;

  // one-step jog of a joint: increment test first, then decrement on the updated value
  function automatic pos_t jog(input pos_t p, input pos_t axis, input cfg_t c);
    pos_t t;
    t = p;
    if (axis > c.high_threshold && t < c.position_max) t = t + 8'd1;
    if (axis < c.low_threshold && t > c.position_min) t = t - 8'd1;
    return t;
  endfunction

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit <= DebounceLimitRst;
      cfg_q.step_interval  <= StepIntervalRst;
      cfg_q.high_threshold <= HighThresholdRst;
      cfg_q.low_threshold  <= LowThresholdRst;
      cfg_q.position_max   <= PositionMaxRst;
      cfg_q.position_min   <= PositionMinRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegDebounceLimit: cfg_q.debounce_limit <= pwdata[CfgW-1:0];
        RegStepInterval:  cfg_q.step_interval  <= pwdata[CfgW-1:0];
        RegHighThreshold: cfg_q.high_threshold <= pwdata[CfgW-1:0];
        RegLowThreshold:  cfg_q.low_threshold  <= pwdata[CfgW-1:0];
        RegPositionMax:   cfg_q.position_max   <= pwdata[CfgW-1:0];
        RegPositionMin:   cfg_q.position_min   <= pwdata[CfgW-1:0];
        default: ; // unmapped indexes are ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegDebounceLimit: cfg_rd = cfg_q.debounce_limit;
      RegStepInterval:  cfg_rd = cfg_q.step_interval;
      RegHighThreshold: cfg_rd = cfg_q.high_threshold;
      RegLowThreshold:  cfg_rd = cfg_q.low_threshold;
      RegPositionMax:   cfg_rd = cfg_q.position_max;
      RegPositionMin:   cfg_rd = cfg_q.position_min;
      default:          cfg_rd = '0;
    endcase
  end
  assign prdata = {{(DataW-CfgW){1'b0}}, cfg_rd};

  // ---------------- handshake ----------------
  // input stage moves on when the result register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_sample_q <= in_i.adc_sample;
      s1_level_q  <= in_i.button_level;
    end
  end

  // ---------------- item update ----------------
  assign sample8 = s1_sample_q[AdcW-1 -: PosW];

  always_comb begin
    // channel store and flip
    x_d    = chan_q ? x_q : sample8;
    y_d    = chan_q ? sample8 : y_q;
    chan_d = ~chan_q;

    // debouncer, 8-bit count cleared at the limit or when the level matches the stable state
    dbc_inc  = dbc_q + 8'd1;
    stable_d = stable_q;
    pulse    = 1'b0;
    if (s1_level_q != stable_q) begin
      if (dbc_inc >= cfg_q.debounce_limit) begin
        stable_d = s1_level_q;
        pulse    = s1_level_q;
        dbc_d    = '0;
      end else begin
        dbc_d = dbc_inc;
      end
    end else begin
      dbc_d = '0;
    end

    // press toggles the mode before the step check sees it
    mode_d = mode_q ^ pulse;

    // step interval counter
    item_inc = item_q + 8'd1;
    step     = item_inc > cfg_q.step_interval;
    item_d   = step ? '0 : item_inc;

    // lower mode drives rotation/arm, upper mode hand/forearm; x on even slots, y on odd
    joint_d = joint_q;
    if (step) begin
      if (mode_d) begin
        joint_d[JointRotation] = jog(joint_q[JointRotation], x_d, cfg_q);
        joint_d[JointArm]      = jog(joint_q[JointArm], y_d, cfg_q);
      end else begin
        joint_d[JointHand]     = jog(joint_q[JointHand], x_d, cfg_q);
        joint_d[JointForearm]  = jog(joint_q[JointForearm], y_d, cfg_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      chan_q   <= 1'b0;
      mode_q   <= 1'b1;
      item_q   <= '0;
      dbc_q    <= '0;
      stable_q <= 1'b0;
      joint_q  <= {NJoint{JointRst}};
    end else if (s1_adv) begin
      x_q      <= x_d;
      y_q      <= y_d;
      chan_q   <= chan_d;
      mode_q   <= mode_d;
      item_q   <= item_d;
      dbc_q    <= dbc_d;
      stable_q <= stable_d;
      joint_q  <= joint_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_o.rotation_pos <= joint_d[JointRotation];
      out_o.arm_pos      <= joint_d[JointArm];
      out_o.hand_pos     <= joint_d[JointHand];
      out_o.forearm_pos  <= joint_d[JointForearm];
      out_o.lower_mode   <= mode_d;
      out_o.next_channel <= chan_d;
      step_out_q         <= step;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.step_taken = step_out_q;

  // ---------------- assertions ----------------
  `JJPC_ASSERT(a_stall_only_when_full,
    in_i.ready || (s1_valid_q && out_valid_q && !out_o.ready),
    "input stalled while the result register can drain")
  `JJPC_ASSERT_NEXT(a_step_clears_counter, s1_adv && step,
    item_q == '0, "item counter not cleared after a step")
  `JJPC_ASSERT_NEXT(a_joints_hold, !s1_adv,
    $stable(joint_q), "joint positions changed without an item")
  `JJPC_ASSERT_NEXT(a_mode_hold, !s1_adv,
    $stable(mode_q) && $stable(chan_q), "mode or channel changed without an item")

endmodule
